>>> src/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types and constants for the tile cache with least recently used
// replacement.
// ----------------------------------------------------------------------------
package tcl_pkg;

  localparam int CFG_W       = 6;
  localparam int SRC_W       = 4;
  localparam int COORD_W     = 22;
  localparam int ZOOM_W      = 5;
  localparam int SLOT_W      = 5;
  localparam int TOTAL_W     = 32;

  localparam int MAX_SLOTS_DEF       = 32;
  localparam int STAMP_BITS_DEF      = 48;
  localparam logic [CFG_W-1:0] DEFAULT_ENTRIES = CFG_W'(20);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  typedef struct packed {
    logic [SRC_W-1:0]   source_kind;
    logic [COORD_W-1:0] tile_x;
    logic [COORD_W-1:0] tile_y;
    logic [ZOOM_W-1:0]  zoom;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> src/tcl_req_if.sv
// ----------------------------------------------------------------------------
// tcl_req_if
// Request channel: lookup or insert of one tile tag.
// ----------------------------------------------------------------------------
interface tcl_req_if;
  import tcl_pkg::*;

  logic               valid;
  logic               ready;
  logic               op;
  logic [SRC_W-1:0]   source_kind;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_y;
  logic [ZOOM_W-1:0]  zoom;

  modport source (output valid, op, source_kind, tile_x, tile_y, zoom, input ready);
  modport sink   (input valid, op, source_kind, tile_x, tile_y, zoom, output ready);

endinterface

>>> src/tcl_rsp_if.sv
// ----------------------------------------------------------------------------
// tcl_rsp_if
// Result channel: hit, slot, eviction flag and running totals.
// ----------------------------------------------------------------------------
interface tcl_rsp_if;
  import tcl_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic               evicted;
  logic [TOTAL_W-1:0] hit_total;
  logic [TOTAL_W-1:0] miss_total;

  modport source (output valid, hit, slot, evicted, hit_total, miss_total, input ready);
  modport sink   (input valid, hit, slot, evicted, hit_total, miss_total, output ready);

endinterface

>>> src/tcl_cfg_if.sv
// ----------------------------------------------------------------------------
// tcl_cfg_if
// Configuration write channel for the slot count register.
// ----------------------------------------------------------------------------
interface tcl_cfg_if;
  import tcl_pkg::*;

  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);

endinterface

>>> src/tcl_ram.sv
// ----------------------------------------------------------------------------
// tcl_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tcl_ctrl.sv
// ----------------------------------------------------------------------------
// tcl_ctrl
// Request sequencer: accept, scan the slots, drain the last read, commit.
// ----------------------------------------------------------------------------
module tcl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  tcl_pkg::ctl_sts_t sts_i,
  output tcl_pkg::ctl_cmd_t cmd_o
);
  import tcl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/tcl_dp.sv
// ----------------------------------------------------------------------------
// tcl_dp
// Tag store datapath: tag RAM, valid bits, scan compare, stamp and counters.
// ----------------------------------------------------------------------------
module tcl_dp #(
  parameter int MAX_SLOTS  = tcl_pkg::MAX_SLOTS_DEF,
  parameter int STAMP_BITS = tcl_pkg::STAMP_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcl_pkg::ctl_cmd_t            cmd_i,
  output tcl_pkg::ctl_sts_t            sts_o,
  input  logic                         op_i,
  input  logic [tcl_pkg::SRC_W-1:0]    source_kind_i,
  input  logic [tcl_pkg::COORD_W-1:0]  tile_x_i,
  input  logic [tcl_pkg::COORD_W-1:0]  tile_y_i,
  input  logic [tcl_pkg::ZOOM_W-1:0]   zoom_i,
  input  logic                         cfg_we_i,
  input  logic [tcl_pkg::CFG_W-1:0]    cfg_data_i,
  output logic                         rsp_valid_o,
  input  logic                         rsp_ready_i,
  output logic                         hit_o,
  output logic [tcl_pkg::SLOT_W-1:0]   slot_o,
  output logic                         evicted_o,
  output logic [tcl_pkg::TOTAL_W-1:0]  hit_total_o,
  output logic [tcl_pkg::TOTAL_W-1:0]  miss_total_o
);
  import tcl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int SUM_W  = (CFG_W > IDX_W + 1) ? CFG_W : IDX_W + 1;
  localparam int WORD_W = TAG_W + STAMP_BITS;

  logic [CFG_W-1:0]      cfg_q;
  logic [MAX_SLOTS-1:0]  valid_q;
  logic                  op_q;
  tag_t                  tag_q;
  logic [IDX_W-1:0]      scan_idx_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  rd_vld_q;
  logic                  found_q;
  logic [IDX_W-1:0]      loc_q;
  logic                  min_seen_q;
  logic [STAMP_BITS-1:0] min_stamp_q;
  logic [IDX_W-1:0]      min_idx_q;
  logic [STAMP_BITS-1:0] clock_q;
  logic [TOTAL_W-1:0]    hits_q, hits_d;
  logic [TOTAL_W-1:0]    misses_q, misses_d;
  logic                  out_valid_q;
  logic                  out_hit_q;
  logic [SLOT_W-1:0]     out_slot_q;
  logic                  out_evicted_q;

  logic [SUM_W-1:0]      cfg_ext;
  logic [IDX_W-1:0]      last_idx;
  logic [WORD_W-1:0]     rd_word;
  tag_t                  rd_tag;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  rd_entry_valid;
  logic                  is_insert;
  logic                  do_stamp;
  logic [IDX_W-1:0]      wr_loc;
  logic [STAMP_BITS-1:0] new_stamp;

  // effective slot count is the register clamped to 1..MAX_SLOTS
  assign cfg_ext = SUM_W'(cfg_q);
  always_comb begin
    priority if (cfg_q == '0) begin
      last_idx = '0;
    end else if (cfg_ext > SUM_W'(MAX_SLOTS)) begin
      last_idx = IDX_W'(MAX_SLOTS - 1);
    end else begin
      last_idx = IDX_W'(cfg_ext - SUM_W'(1));
    end
  end

  assign rd_tag         = tag_t'(rd_word[WORD_W-1 -: TAG_W]);
  assign rd_stamp       = rd_word[STAMP_BITS-1:0];
  assign rd_entry_valid = valid_q[rd_idx_q];
  assign is_insert      = (op_q == OP_INSERT);
  assign do_stamp       = is_insert || found_q;
  assign new_stamp      = clock_q + STAMP_BITS'(1);

  always_comb begin
    if (found_q) begin
      wr_loc = loc_q;
    end else if (is_insert) begin
      wr_loc = min_idx_q;
    end else begin
      wr_loc = '0;
    end
  end

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    if (!is_insert) begin
      if (found_q) begin
        hits_d = hits_q + TOTAL_W'(1);
      end else begin
        misses_d = misses_q + TOTAL_W'(1);
      end
    end
  end

  assign sts_o.scan_last = (scan_idx_q == last_idx);
  assign sts_o.out_free  = !out_valid_q || rsp_ready_i;

  tcl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && do_stamp),
    .waddr_i (wr_loc),
    .wdata_i ({tag_q, new_stamp}),
    .raddr_i (scan_idx_q),
    .rdata_o (rd_word)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= DEFAULT_ENTRIES;
      valid_q     <= '0;
      scan_idx_q  <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      min_seen_q  <= 1'b0;
      clock_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
      if (cfg_we_i) begin
        cfg_q   <= cfg_data_i;
        valid_q <= '0;
      end
      if (cmd_i.load) begin
        scan_idx_q <= '0;
        found_q    <= 1'b0;
        min_seen_q <= 1'b0;
      end else if (cmd_i.scan) begin
        scan_idx_q <= scan_idx_q + IDX_W'(1);
      end
      if (rd_vld_q) begin
        if (is_insert) begin
          if (!found_q && !rd_entry_valid) begin
            found_q <= 1'b1;
          end
          if (rd_entry_valid && (!min_seen_q || rd_stamp < min_stamp_q)) begin
            min_seen_q <= 1'b1;
          end
        end else if (!found_q && rd_entry_valid && rd_tag == tag_q) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        if (do_stamp) begin
          clock_q <= new_stamp;
        end
        if (is_insert) begin
          valid_q[wr_loc] <= 1'b1;
        end
        hits_q      <= hits_d;
        misses_q    <= misses_d;
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      tag_q <= '{source_kind: source_kind_i, tile_x: tile_x_i,
                 tile_y: tile_y_i, zoom: zoom_i};
    end
    rd_idx_q <= scan_idx_q;
    if (rd_vld_q) begin
      if (is_insert) begin
        if (!found_q && !rd_entry_valid) begin
          loc_q <= rd_idx_q;
        end
        if (rd_entry_valid && (!min_seen_q || rd_stamp < min_stamp_q)) begin
          min_stamp_q <= rd_stamp;
          min_idx_q   <= rd_idx_q;
        end
      end else if (!found_q && rd_entry_valid && rd_tag == tag_q) begin
        loc_q <= rd_idx_q;
      end
    end
    if (cmd_i.commit) begin
      out_hit_q     <= !is_insert && found_q;
      out_slot_q    <= SLOT_W'(wr_loc);
      out_evicted_q <= is_insert && !found_q;
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign hit_o        = out_hit_q;
  assign slot_o       = out_slot_q;
  assign evicted_o    = out_evicted_q;
  assign hit_total_o  = hits_q;
  assign miss_total_o = misses_q;

  // commit never overwrites a result that is still waiting
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || rsp_ready_i))
    else $error("commit while result pending");

  // an insert leaves its slot valid
  a_insert_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && is_insert) |=> valid_q[$past(wr_loc)])
    else $error("inserted slot not valid");

  // the access clock moves only on a committed stamp
  a_clock_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(clock_q))
    else $error("access clock moved without commit");

  // the written slot lies inside the slots in use
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (wr_loc <= last_idx))
    else $error("slot outside range in use");

endmodule

>>> src/tile_cache_lru.sv
// ----------------------------------------------------------------------------
// tile_cache_lru
// Fully associative tile tag cache with least recently used replacement.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+--------------------------------------------
//  req_i    | in  | valid / ready | op, source_kind, tile_x, tile_y, zoom
//  rsp_o    | out | valid / ready | hit, slot, evicted, hit_total, miss_total
//  cfg_i    | in  | valid / ready | entries_in_use (always ready)
//
//  Scan: n slots per request, n being entries_in_use clamped to 1..MAX_SLOTS.
//    The tag RAM is scanned one slot per cycle through its single read port,
//    then a drain state takes the last read and a commit state writes the result.
//  Reset: valid bits clear at once, entries_in_use returns to 20, the access
//    clock and both totals go to zero; no clearing pass is needed.
//  Stalls: the result sits in an output register; the next request is taken
//    while it waits, and its commit holds until the register is free.
//
module tile_cache_lru #(
  parameter int MAX_SLOTS  = tcl_pkg::MAX_SLOTS_DEF,
  parameter int STAMP_BITS = tcl_pkg::STAMP_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tcl_req_if.sink      req_i,
  tcl_rsp_if.source    rsp_o,
  tcl_cfg_if.sink      cfg_i
);
  import tcl_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // writes are taken straight into the register, so the register port never stalls
  assign cfg_i.ready = 1'b1;

  // sequencer: accept, scan, drain, commit
  tcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // tag RAM, valid bits, compare, stamp search and totals
  tcl_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .STAMP_BITS (STAMP_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (req_i.op),
    .source_kind_i (req_i.source_kind),
    .tile_x_i      (req_i.tile_x),
    .tile_y_i      (req_i.tile_y),
    .zoom_i        (req_i.zoom),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.entries_in_use),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready),
    .hit_o         (rsp_o.hit),
    .slot_o        (rsp_o.slot),
    .evicted_o     (rsp_o.evicted),
    .hit_total_o   (rsp_o.hit_total),
    .miss_total_o  (rsp_o.miss_total)
  );

endmodule
